// ===== hw/rtl/qpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qpm_pkg;

  localparam int unsigned ANGLE_W = 24;
  localparam int unsigned CPR_W   = 16;
  localparam int unsigned POS_W   = 32;

  localparam logic [CPR_W-1:0] CPR_RESET = 16'd1440;

  // 360 degrees per revolution is 45 * 2^3, so the angle denominator splits
  // into an odd factor and a shift that grows with the fraction bits.
  localparam int unsigned DEN_ODD   = 45;
  localparam int unsigned DEN_SHIFT = 3;

  typedef struct packed {
    logic                      kind;
    logic                      enc_a;
    logic                      enc_b;
    logic signed [ANGLE_W-1:0] move_angle;
  } in_t;

  typedef struct packed {
    logic                    drive_in1;
    logic                    drive_in2;
    logic                    drive_enable;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] target;
  } out_t;

  typedef struct packed {
    logic sample;
    logic capture;
    logic mul;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/qpm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qpm_ctrl
  import qpm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_kind_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  sts_t      sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   in_accept;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.sample  = in_accept && !in_kind_i;
    cmd_o.capture = in_accept && in_kind_i;
    cmd_o.mul     = (state_q == ST_MUL);
    cmd_o.step    = (state_q == ST_DIV);
    cmd_o.finish  = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.sample || cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (sts_i.div_last) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while a command is in progress");

  a_cmd_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_MUL))
    else $error("accepted command did not start the multiply");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && !sts_i.div_last) |=> (state_q == ST_DIV))
    else $error("division left before its last step");

  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.sample || cmd_o.finish) |=> out_valid_q)
    else $error("result loaded without valid");

endmodule
`default_nettype wire

// ===== hw/rtl/qpm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qpm_dp
  import qpm_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CPR_W-1:0] cfg_wdata_i,
  input  in_t                   in_data_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output out_t                  out_data_o
);

  localparam int unsigned PROD_W = ANGLE_W + CPR_W;
  localparam int unsigned SHIFT  = ANGLE_FRAC_BITS + DEN_SHIFT;
  localparam int unsigned XW     = PROD_W - SHIFT;
  localparam int unsigned REC_K  = XW + $clog2(DEN_ODD);
  localparam int unsigned REC_W  = XW + 1;
  localparam int unsigned HW     = (REC_W + 1) / 2;
  localparam int unsigned ACC_W  = XW + REC_W;
  localparam int unsigned LO_W   = XW + HW;
  localparam int unsigned HI_W   = ACC_W - HW;

  localparam logic [REC_W-1:0] REC_M =
    REC_W'(((64'd1 << REC_K) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD));
  localparam logic [HW-1:0]       REC_LO = REC_M[HW-1:0];
  localparam logic [REC_W-HW-1:0] REC_HI = REC_M[REC_W-1:HW];

  localparam logic [3:0] CODE_UP0 = 4'b1101;
  localparam logic [3:0] CODE_UP1 = 4'b0100;
  localparam logic [3:0] CODE_UP2 = 4'b0010;
  localparam logic [3:0] CODE_UP3 = 4'b1011;
  localparam logic [3:0] CODE_DN0 = 4'b1110;
  localparam logic [3:0] CODE_DN1 = 4'b0111;
  localparam logic [3:0] CODE_DN2 = 4'b0001;
  localparam logic [3:0] CODE_DN3 = 4'b1000;

  function automatic logic near_stop(input logic [POS_W-1:0] diff);
    return (diff == '0) || (diff == POS_W'(1)) || (diff == '1);
  endfunction

  logic [CPR_W-1:0]   cpr_q;
  logic [1:0]         pins_q, pins_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   tgt_q, tgt_d;
  logic               in1_q, in1_d;
  logic               in2_q, in2_d;
  logic               en_q, en_d;
  out_t               out_q;

  logic [ANGLE_W-1:0] angle_q;
  logic [XW-1:0]      x_q;
  logic [ACC_W-1:0]   acc_q;
  logic               step_q;

  logic               neg;
  logic [ANGLE_W-1:0] mag;
  logic [PROD_W-1:0]  prod;
  logic [LO_W-1:0]    part_lo;
  logic [HI_W-1:0]    part_hi;
  logic [POS_W-1:0]   quo;
  logic [POS_W-1:0]   cnt;
  logic               fwd;
  logic [3:0]         code;

  assign neg     = angle_q[ANGLE_W-1];
  assign mag     = neg ? (~angle_q + ANGLE_W'(1)) : angle_q;
  assign prod    = PROD_W'(mag) * PROD_W'(cpr_q);
  assign part_lo = LO_W'(x_q) * LO_W'(REC_LO);
  assign part_hi = HI_W'(x_q) * HI_W'(REC_HI);
  assign quo     = POS_W'(acc_q[ACC_W-1:REC_K]);
  assign cnt     = neg ? (~quo + POS_W'(1)) : quo;
  assign fwd     = (cnt != '0) && !cnt[POS_W-1];
  assign code    = {pins_q, in_data_i.enc_a, in_data_i.enc_b};

  assign sts_o.div_last = step_q;

  always_comb begin
    pins_d = pins_q;
    pos_d  = pos_q;
    tgt_d  = tgt_q;
    in1_d  = in1_q;
    in2_d  = in2_q;
    en_d   = en_q;
    if (cmd_i.sample) begin
      pins_d = {in_data_i.enc_a, in_data_i.enc_b};
      case (code)
        CODE_UP0, CODE_UP1, CODE_UP2, CODE_UP3: pos_d = pos_q + POS_W'(1);
        CODE_DN0, CODE_DN1, CODE_DN2, CODE_DN3: pos_d = pos_q - POS_W'(1);
        default:                                pos_d = pos_q;
      endcase
      en_d = en_q && !near_stop(tgt_q - pos_d);
    end
    if (cmd_i.finish) begin
      tgt_d = pos_q + cnt;
      in1_d = fwd;
      in2_d = !fwd;
      en_d  = !near_stop(cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q  <= CPR_RESET;
      pins_q <= '0;
      pos_q  <= '0;
      tgt_q  <= '0;
      in1_q  <= 1'b0;
      in2_q  <= 1'b0;
      en_q   <= 1'b0;
      out_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cpr_q <= cfg_wdata_i;
      end
      pins_q <= pins_d;
      pos_q  <= pos_d;
      tgt_q  <= tgt_d;
      in1_q  <= in1_d;
      in2_q  <= in2_d;
      en_q   <= en_d;
      if (cmd_i.sample || cmd_i.finish) begin
        out_q.drive_in1    <= in1_d;
        out_q.drive_in2    <= in2_d;
        out_q.drive_enable <= en_d;
        out_q.position     <= pos_d;
        out_q.target       <= tgt_d;
      end
    end
  end

  // The quotient by the odd factor comes from a multiply by its rounded-up
  // reciprocal, taken in two halves, the low half first and then the high half.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      angle_q <= in_data_i.move_angle;
    end
    if (cmd_i.mul) begin
      x_q    <= prod[PROD_W-1:SHIFT];
      step_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (step_q) begin
        acc_q <= acc_q + {part_hi, {HW{1'b0}}};
      end else begin
        acc_q <= ACC_W'(part_lo);
      end
      step_q <= 1'b1;
    end
  end

  assign out_data_o = out_q;

  a_dir_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_q.drive_in1 && out_q.drive_in2))
    else $error("both bridge inputs selected");

  a_enable_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.drive_enable |-> !near_stop(out_q.target - out_q.position))
    else $error("drive enabled within one count of the target");

  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !quo[POS_W-1])
    else $error("move count out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/quadrature_position_move.sv =====
// Quadrature encoder decoder with bang-bang relative position moves.
// Input items arrive on in_valid_i / in_stall_o / in_data_i. An item is either
// a sample of the two encoder pins or a move command with a signed angle.
// Every item produces exactly one result item on out_valid_o / out_stall_i /
// out_data_o holding the bridge levels, the enable, the position and target.
// A pin sample is decoded in the cycle it is accepted, so its result is valid
// in the next cycle, and samples are taken at one item per cycle while the
// output is not stalled. A move command runs the angle multiply, then a
// two-step multiply by the reciprocal of 45, then a finish step that loads
// the result once the output is free; no item is taken until it is done.
// counts_per_rev must be written through cfg_we_i / cfg_wdata_i only while
// idle; the block itself does not enforce this. Reset clears the position,
// target and pin history, stops the drive and loads 1440 counts per
// revolution. The result sits in an output register; a stalled result holds,
// and a new item is taken in the cycle that the waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_position_move
  import qpm_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CPR_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_t                  out_data_o
);

  cmd_t cmd;
  sts_t sts;

  qpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_data_i.kind),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qpm_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
